// ===== rtl/core/lzss_pkg.sv =====
// Package for the LZSS pixel decompressor: command, status, phase and FSM state
// codes, config register indices, shared widths and controller/datapath structs. No dependencies.
package lzss_pkg;

    localparam int HistDepth = 4096;
    localparam int HistAw    = 12;
    localparam int MaxSide   = 1024;
    localparam int CntW      = 22;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PULL  = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_TAKEN   = 3'd0,
        ST_REFUSED = 3'd1,
        ST_PIXEL   = 3'd2,
        ST_NOPIX   = 3'd3,
        ST_DONE    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_HDR2 = 3'd2,
        PH_FLAG = 3'd3,
        PH_ITEM = 3'd4,
        PH_REF1 = 3'd5,
        PH_REF2 = 3'd6,
        PH_STOP = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_READ = 2'd1,
        FSM_EXEC = 2'd2,
        FSM_OUT  = 2'd3
    } fsm_t;

    localparam logic [3:0] RegWidth  = 4'd0;
    localparam logic [3:0] RegHeight = 4'd1;

    // controller -> datapath
    typedef struct packed {
        logic hist_rd;    // launch history read for copy
        logic exec;       // execute the latched transaction
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_read; // latched pull will copy a history byte
    } dp_stat_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pixel_value;
        logic       pixel_transparent;
        logic       pixel_last;
    } result_t;

endpackage

// ===== rtl/core/lzss_if.sv =====
// Valid/ready channel interfaces for the decompressor.
// Depends on nothing.
interface lzss_in_if (input logic clk);
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, cmd, in_byte, in_last, input ready);
    modport sink (input valid, cmd, in_byte, in_last, output ready);
endinterface

interface lzss_out_if (input logic clk);
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] pixel_value;
    logic       pixel_transparent;
    logic       pixel_last;
    modport source (output valid, status, pixel_value, pixel_transparent, pixel_last,
                    input ready);
    modport sink (input valid, status, pixel_value, pixel_transparent, pixel_last,
                  output ready);
endinterface

interface lzss_cfg_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lzss_pixel_decompressor.sv =====
// LZSS pixel decompressor top level: controller plus datapath.
// A push, pull or start transaction is answered after acceptance through the history
// read slot, execute and result states; a new transaction is taken only once the result
// has been taken. The unused command is accepted in idle and gives no result.
// rst_n clears all control state asynchronously; history is not cleared.
// Depends on lzss_pkg, lzss_if, lzss_ctrl and lzss_dp.
module lzss_pixel_decompressor (
    input  logic        clk,
    input  logic        rst_n,
    lzss_in_if.sink     in_ch,
    lzss_out_if.source  out_ch,
    lzss_cfg_if.sink    cfg
);
    lzss_pkg::dp_cmd_t  dcmd;
    lzss_pkg::dp_stat_t dstat;
    lzss_pkg::result_t  res;
    logic               latch;

    // config writes are always taken
    assign cfg.ready = 1'b1;

    lzss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .in_cmd    (in_ch.cmd),
        .stat      (dstat),
        .cmd       (dcmd),
        .latch     (latch)
    );

    lzss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .latch     (latch),
        .in_cmd    (in_ch.cmd),
        .in_byte   (in_ch.in_byte),
        .in_last   (in_ch.in_last),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (dcmd),
        .stat      (dstat),
        .res       (res)
    );

    // result register drives the port directly
    assign out_ch.status            = res.status;
    assign out_ch.pixel_value       = res.pixel_value;
    assign out_ch.pixel_transparent = res.pixel_transparent;
    assign out_ch.pixel_last        = res.pixel_last;

    // only one side handshakes at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input and output both open");

    // last pixel only with pixel status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.pixel_last |-> out_ch.status == lzss_pkg::ST_PIXEL)
        else $error("pixel_last without pixel");

    // accepted real command leads to a result after the read and execute states
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.cmd != lzss_pkg::CMD_NONE
        |-> ##3 out_ch.valid)
        else $error("result missing");
endmodule

// ===== rtl/core/lzss_ctrl.sv =====
// Controller FSM of the LZSS decompressor: sequences accept, optional
// history read, execute and result hand-off. Depends on lzss_pkg.
module lzss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          in_cmd,
    input  lzss_pkg::dp_stat_t  stat,
    output lzss_pkg::dp_cmd_t   cmd,
    output logic                latch
);
    lzss_pkg::fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzss_pkg::FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        latch      = 1'b0;
        cmd        = '0;
        case (state_reg)
            lzss_pkg::FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_cmd != lzss_pkg::CMD_NONE)
                begin
                    latch      = 1'b1;
                    state_next = lzss_pkg::FSM_READ;
                end
            end
            lzss_pkg::FSM_READ:
            begin
                cmd.hist_rd = stat.needs_read;
                state_next  = lzss_pkg::FSM_EXEC;
            end
            lzss_pkg::FSM_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = lzss_pkg::FSM_OUT;
            end
            lzss_pkg::FSM_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = lzss_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = lzss_pkg::FSM_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/lzss_dp.sv =====
// Datapath of the LZSS decompressor: history memory, parser, group tracker,
// pixel output and result register. Depends on lzss_pkg.
module lzss_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                latch,
    input  logic [1:0]          in_cmd,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [10:0]         cfg_data,
    input  lzss_pkg::dp_cmd_t   cmd,
    output lzss_pkg::dp_stat_t  stat,
    output lzss_pkg::result_t   res
);
    localparam int CW = lzss_pkg::CntW;
    localparam int AW = lzss_pkg::HistAw;

    logic [7:0] hist_mem [lzss_pkg::HistDepth];
    logic [7:0] hist_q;

    logic [10:0] width_reg, height_reg;
    logic [CW-1:0] area_reg;

    logic [1:0]  cmd_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic [CW-1:0] dec_reg, extra_reg, nmark_reg, omark_reg, pout_reg;
    logic          mvalid_reg, rvalid_reg, ovalid_reg;
    logic [7:0]    mrun_reg, run_reg, oval_reg;
    logic [8:0]    tleft_reg;
    logic [7:0]    fshift_reg;
    logic [3:0]    fbits_reg;
    lzss_pkg::phase_t phase_reg;
    logic [11:0]   dist_reg;
    logic [8:0]    crem_reg;
    lzss_pkg::result_t res_reg;

    // area of clamped sides, registered; user must keep config static while busy, the block does not enforce it
    logic [10:0] wc, hc;
    assign wc = (width_reg  > 11'(lzss_pkg::MaxSide)) ? 11'(lzss_pkg::MaxSide) : width_reg;
    assign hc = (height_reg > 11'(lzss_pkg::MaxSide)) ? 11'(lzss_pkg::MaxSide) : height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1;
            height_reg <= 11'd1;
            area_reg   <= 22'd1;
        end
        else
        begin
            if (cfg_we && cfg_index == lzss_pkg::RegWidth)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == lzss_pkg::RegHeight)
            begin
                height_reg <= cfg_data;
            end
            area_reg <= CW'(wc) * CW'(hc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch)
        begin
            cmd_reg  <= in_cmd;
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    // pull that finds nothing to give but a copy pending
    logic pend;
    assign pend = (tleft_reg != 9'd0) || ovalid_reg;
    assign stat.needs_read = (cmd_reg == lzss_pkg::CMD_PULL) && (pout_reg < area_reg)
                             && !pend && (crem_reg != 9'd0);

    logic [AW-1:0] rd_addr;
    assign rd_addr = AW'(dec_reg - CW'(dist_reg));

    // next-state logic for one transaction
    logic [CW-1:0] n_dec, n_extra, n_nmark, n_omark, n_pout;
    logic          n_mvalid, n_rvalid, n_ovalid;
    logic [7:0]    n_mrun, n_run, n_oval, n_fshift;
    logic [8:0]    n_tleft, n_crem;
    logic [3:0]    n_fbits;
    lzss_pkg::phase_t n_phase;
    logic [11:0]   n_dist;
    lzss_pkg::result_t n_res;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    logic          em_go, em_hdr, bit7, give_go, give_tr, gave;
    logic [7:0]    em_b, give_v;
    logic [CW-1:0] mark, est, budget;
    logic [8:0]    rep;
    logic          sc_go;

    always_comb
    begin
        n_dec = dec_reg; n_extra = extra_reg; n_nmark = nmark_reg; n_omark = omark_reg;
        n_pout = pout_reg; n_mvalid = mvalid_reg; n_rvalid = rvalid_reg;
        n_ovalid = ovalid_reg; n_mrun = mrun_reg; n_run = run_reg; n_oval = oval_reg;
        n_fshift = fshift_reg; n_tleft = tleft_reg; n_crem = crem_reg;
        n_fbits = fbits_reg; n_phase = phase_reg; n_dist = dist_reg;
        n_res = '0;
        em_go = 1'b0; em_hdr = 1'b0; em_b = byte_reg;
        give_go = 1'b0; give_tr = 1'b0; give_v = 8'd0; gave = 1'b0;
        sc_go = 1'b0; rep = 9'd0;
        we = 1'b0; waddr = AW'(dec_reg); wdata = em_b;
        budget = {area_reg[CW-2:0], 1'b0};
        bit7 = fshift_reg[7];
        mark = '0; est = '0;

        case (lzss_pkg::cmd_t'(cmd_reg))
            lzss_pkg::CMD_PUSH:
            begin
                if (pend || crem_reg != 9'd0)
                begin
                    n_res.status = lzss_pkg::ST_REFUSED;
                end
                else
                begin
                    n_res.status = lzss_pkg::ST_TAKEN;
                    case (phase_reg)
                        lzss_pkg::PH_HDR0:
                        begin
                            n_extra = CW'(byte_reg) - CW'(2);
                            n_nmark = CW'(byte_reg);
                            em_go = 1'b1; em_hdr = 1'b1; n_phase = lzss_pkg::PH_HDR1;
                        end
                        lzss_pkg::PH_HDR1:
                        begin
                            n_nmark = nmark_reg + CW'(byte_reg);
                            em_go = 1'b1; em_hdr = 1'b1; n_phase = lzss_pkg::PH_HDR2;
                        end
                        lzss_pkg::PH_HDR2:
                        begin
                            em_go = 1'b1; em_hdr = 1'b1;
                            n_phase = lzss_pkg::PH_FLAG; // resolved below
                        end
                        lzss_pkg::PH_FLAG:
                        begin
                            n_fshift = byte_reg; n_fbits = 4'd8;
                            n_phase = lzss_pkg::PH_ITEM;
                        end
                        lzss_pkg::PH_ITEM:
                        begin
                            n_fshift = {fshift_reg[6:0], 1'b0};
                            if (fbits_reg != 4'd0)
                            begin
                                n_fbits = fbits_reg - 4'd1;
                            end
                            if (!bit7)
                            begin
                                em_go = 1'b1;
                            end
                            else
                            begin
                                n_dist = {4'd0, byte_reg};
                                n_phase = lzss_pkg::PH_REF1;
                            end
                        end
                        lzss_pkg::PH_REF1:
                        begin
                            n_dist = {byte_reg[3:0], dist_reg[7:0]};
                            if (byte_reg[7:4] == 4'd0)
                            begin
                                n_phase = lzss_pkg::PH_REF2;
                            end
                            else
                            begin
                                sc_go = 1'b1; rep = {5'd0, byte_reg[7:4]};
                            end
                        end
                        lzss_pkg::PH_REF2:
                        begin
                            sc_go = 1'b1; rep = 9'(byte_reg) + 9'h10;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lzss_pkg::CMD_PULL:
            begin
                if (pout_reg >= area_reg)
                begin
                    n_res.status = lzss_pkg::ST_DONE;
                end
                else if (pend)
                begin
                    give_go = 1'b1;
                end
                else if (crem_reg != 9'd0)
                begin
                    em_go = 1'b1; em_b = hist_q;
                    n_crem = crem_reg - 9'd1;
                end
                else if (phase_reg == lzss_pkg::PH_STOP)
                begin
                    gave = 1'b1; give_v = 8'd0;
                end
                else
                begin
                    n_res.status = lzss_pkg::ST_NOPIX;
                end
            end
            default:
            begin
            end
        endcase

        // byte emission into history, group tracker and pixel output tracker
        if (em_go && dec_reg < budget)
        begin
            if (!em_hdr)
            begin
                mark = nmark_reg - extra_reg;
                if (dec_reg == mark || mvalid_reg)
                begin
                    if (!mvalid_reg)
                    begin
                        n_mrun = em_b; n_mvalid = 1'b1;
                    end
                    else
                    begin
                        n_extra  = n_extra + CW'(mrun_reg) - CW'(2);
                        n_nmark  = nmark_reg + CW'(mrun_reg) + CW'(em_b);
                        n_mvalid = 1'b0;
                    end
                end
            end
            we = 1'b1; wdata = em_b;
            n_dec = dec_reg + CW'(1);
            if (pout_reg < area_reg)
            begin
                if (rvalid_reg)
                begin
                    n_omark = omark_reg + CW'(run_reg) + CW'(em_b);
                    n_tleft = {1'b0, run_reg};
                    n_rvalid = 1'b0;
                end
                else if (pout_reg == omark_reg)
                begin
                    n_run = em_b; n_rvalid = 1'b1;
                end
                else
                begin
                    n_oval = em_b; n_ovalid = 1'b1;
                end
            end
        end
        if (cmd_reg == lzss_pkg::CMD_PULL && crem_reg != 9'd0 && !pend
            && pout_reg < area_reg && n_dec >= budget)
        begin
            n_crem = 9'd0;
        end

        // phase resolution: start and end of copy, literal, header, bad reference, last byte
        est = n_dec + n_extra;
        if (sc_go)
        begin
            if (CW'(n_dist) > dec_reg || n_dist == 12'd0)
            begin
                n_phase = (est < area_reg) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_STOP;
            end
            else
            begin
                n_crem = rep + 9'd2; n_phase = lzss_pkg::PH_ITEM;
            end
        end
        if (cmd_reg == lzss_pkg::CMD_PUSH && !pend && crem_reg == 9'd0)
        begin
            if (phase_reg == lzss_pkg::PH_HDR2
                || (phase_reg == lzss_pkg::PH_ITEM && !bit7))
            begin
                if (phase_reg == lzss_pkg::PH_ITEM && n_fbits != 4'd0)
                begin
                    n_phase = lzss_pkg::PH_ITEM;
                end
                else
                begin
                    n_phase = (est < area_reg) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_STOP;
                end
            end
            if (last_reg)
            begin
                n_phase = lzss_pkg::PH_STOP; n_crem = 9'd0;
            end
        end
        if (cmd_reg == lzss_pkg::CMD_PULL && crem_reg != 9'd0 && !pend
            && pout_reg < area_reg && n_crem == 9'd0)
        begin
            if (fbits_reg == 4'd0)
            begin
                n_phase = (est < area_reg) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_STOP;
            end
            else
            begin
                n_phase = lzss_pkg::PH_ITEM;
            end
        end

        // try_give after a copy byte, or directly
        if (cmd_reg == lzss_pkg::CMD_PULL && crem_reg != 9'd0 && !pend
            && pout_reg < area_reg)
        begin
            if (n_tleft != 9'd0 || n_ovalid)
            begin
                give_go = 1'b1;
            end
            else
            begin
                n_res.status = lzss_pkg::ST_NOPIX;
            end
        end
        if (give_go)
        begin
            gave = 1'b1;
            if (n_tleft != 9'd0)
            begin
                n_tleft = n_tleft - 9'd1; give_tr = 1'b1;
            end
            else
            begin
                n_ovalid = 1'b0; give_v = n_oval;
            end
        end
        if (gave)
        begin
            n_pout = pout_reg + CW'(1);
            n_res.status = lzss_pkg::ST_PIXEL;
            n_res.pixel_value = give_v;
            n_res.pixel_transparent = give_tr;
            if (n_pout >= area_reg)
            begin
                n_res.pixel_last = 1'b1;
                n_tleft = 9'd0; n_ovalid = 1'b0; n_crem = 9'd0;
                n_phase = lzss_pkg::PH_STOP;
            end
        end
        waddr = AW'(dec_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd)
        begin
            hist_q <= hist_mem[rd_addr];
        end
        if (cmd.exec && we)
        begin
            hist_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= '0; extra_reg <= '0; nmark_reg <= '0; omark_reg <= '0;
            pout_reg <= '0; mvalid_reg <= 1'b0; rvalid_reg <= 1'b0; ovalid_reg <= 1'b0;
            mrun_reg <= '0; run_reg <= '0; oval_reg <= '0; tleft_reg <= '0;
            fshift_reg <= '0; fbits_reg <= '0; phase_reg <= lzss_pkg::PH_HDR0;
            dist_reg <= '0; crem_reg <= '0; res_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (cmd_reg == lzss_pkg::CMD_START)
            begin
                dec_reg <= '0; extra_reg <= '0; nmark_reg <= '0; omark_reg <= '0;
                pout_reg <= '0; mvalid_reg <= 1'b0; rvalid_reg <= 1'b0;
                ovalid_reg <= 1'b0; mrun_reg <= '0; run_reg <= '0; oval_reg <= '0;
                tleft_reg <= '0; fshift_reg <= '0; fbits_reg <= '0;
                phase_reg <= lzss_pkg::PH_HDR0; dist_reg <= '0; crem_reg <= '0;
                res_reg <= '0;
            end
            else
            begin
                dec_reg <= n_dec; extra_reg <= n_extra; nmark_reg <= n_nmark;
                omark_reg <= n_omark; pout_reg <= n_pout; mvalid_reg <= n_mvalid;
                rvalid_reg <= n_rvalid; ovalid_reg <= n_ovalid; mrun_reg <= n_mrun;
                run_reg <= n_run; oval_reg <= n_oval; tleft_reg <= n_tleft;
                fshift_reg <= n_fshift; fbits_reg <= n_fbits; phase_reg <= n_phase;
                dist_reg <= n_dist; crem_reg <= n_crem; res_reg <= n_res;
            end
        end
    end

    assign res = res_reg;
endmodule

// ===== tb/sv/tb_lzss_pixel_decompressor.sv =====
// Self-checking testbench for the LZSS pixel decompressor: a behavioural
// predictor of the decoder drives expectations, compared against each result.
// Depends on lzss_pkg, lzss_if and the lzss_pixel_decompressor RTL.
module tb_lzss_pixel_decompressor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    lzss_in_if  in_ch (clk);
    lzss_out_if out_ch (clk);
    lzss_cfg_if cfg (clk);

    lzss_pixel_decompressor i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the decoder
    // ---------------------------------------------------------------
    logic [7:0]  hist_mem [lzss_pkg::HistDepth];
    logic [10:0] cur_width, cur_height;
    logic [31:0] n_decoded, n_extra, marker_next;
    logic        mark_held;
    logic [31:0] mark_len;
    logic [31:0] marker_out, n_pixels;
    logic        run_held;
    logic [31:0] run_len;
    logic [31:0] transp_left;
    logic        opq_held;
    logic [7:0]  opq_byte;
    logic [7:0]  flags;
    int          flags_left;
    lzss_pkg::phase_t phase;
    logic [31:0] ref_dist, ref_left;

    lzss_pkg::result_t pixel_q[$];   // expected results, oldest first
    int          n_errors = 0;
    int          n_sent = 0;         // input transactions accepted
    int          idle_pct_in = 16;
    int          idle_pct_out = 16;
    bit          out_hold = 1'b0;
    int          quiet_cycles = 0;

    function automatic longint img_area();
        longint w, h;
        w = (cur_width > lzss_pkg::MaxSide) ? lzss_pkg::MaxSide : cur_width;
        h = (cur_height > lzss_pkg::MaxSide) ? lzss_pkg::MaxSide : cur_height;
        return w * h;
    endfunction

    function automatic void clear_decoder();
        n_decoded = 0; n_extra = 0; marker_next = 0;
        mark_held = 0; mark_len = 0;
        marker_out = 0; n_pixels = 0;
        run_held = 0; run_len = 0; transp_left = 0;
        opq_held = 0; opq_byte = 0;
        flags = 0; flags_left = 0;
        phase = lzss_pkg::PH_HDR0; ref_dist = 0; ref_left = 0;
    endfunction

    function automatic void emit(logic [7:0] b, bit is_hdr);
        longint a;
        logic [31:0] mk;
        a = img_area();
        if (longint'(n_decoded) >= 2 * a) return;
        if (!is_hdr)
        begin
            mk = (marker_next - n_extra) & 32'h3FFFFF;
            if ((n_decoded & 32'h3FFFFF) == mk || mark_held)
            begin
                if (!mark_held)
                begin
                    mark_len = b; mark_held = 1;
                end
                else
                begin
                    n_extra = (n_extra + mark_len - 2) & 32'h3FFFFF;
                    marker_next = (marker_next + mark_len + b) & 32'h3FFFFF;
                    mark_held = 0;
                end
            end
        end
        hist_mem[n_decoded % lzss_pkg::HistDepth] = b;
        n_decoded++;
        if (longint'(n_pixels) >= a) return;
        if (run_held)
        begin
            marker_out = (marker_out + run_len + b) & 32'h3FFFFF;
            transp_left = run_len;
            run_held = 0;
        end
        else if ((n_pixels & 32'h3FFFFF) == marker_out)
        begin
            run_len = b; run_held = 1;
        end
        else
        begin
            opq_byte = b; opq_held = 1;
        end
    endfunction

    function automatic void to_flag();
        longint est;
        est = (n_decoded + n_extra) & 32'h3FFFFF;
        phase = (est < img_area()) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_STOP;
    endfunction

    function automatic void next_item();
        if (flags_left == 0) to_flag();
        else phase = lzss_pkg::PH_ITEM;
    endfunction

    function automatic void begin_copy(logic [31:0] rep);
        if (ref_dist == 0 || ref_dist > n_decoded)
        begin
            to_flag();
            return;
        end
        ref_left = rep + 2;
        phase = lzss_pkg::PH_ITEM;
    endfunction

    function automatic void copy_byte();
        emit(hist_mem[(n_decoded - ref_dist) % lzss_pkg::HistDepth], 1'b0);
        ref_left--;
        if (longint'(n_decoded) >= 2 * img_area()) ref_left = 0;
        if (ref_left == 0) next_item();
    endfunction

    function automatic lzss_pkg::result_t give_pixel(logic [7:0] v, logic t);
        lzss_pkg::result_t r;
        n_pixels++;
        r = '{status: lzss_pkg::ST_PIXEL, pixel_value: v, pixel_transparent: t,
              pixel_last: 1'b0};
        if (longint'(n_pixels) >= img_area())
        begin
            r.pixel_last = 1'b1;
            transp_left = 0; opq_held = 0; ref_left = 0; phase = lzss_pkg::PH_STOP;
        end
        return r;
    endfunction

    function automatic bit pending_pixel(output lzss_pkg::result_t r);
        r = '0;
        if (transp_left > 0)
        begin
            transp_left--;
            r = give_pixel(8'h00, 1'b1);
            return 1;
        end
        if (opq_held)
        begin
            opq_held = 0;
            r = give_pixel(opq_byte, 1'b0);
            return 1;
        end
        return 0;
    endfunction

    function automatic void feed_byte(logic [7:0] b);
        logic bit7;
        case (phase)
            lzss_pkg::PH_HDR0:
            begin
                n_extra = (32'(b) - 2) & 32'h3FFFFF; marker_next = b;
                emit(b, 1'b1); phase = lzss_pkg::PH_HDR1;
            end
            lzss_pkg::PH_HDR1:
            begin
                marker_next = (marker_next + b) & 32'h3FFFFF;
                emit(b, 1'b1); phase = lzss_pkg::PH_HDR2;
            end
            lzss_pkg::PH_HDR2:
            begin
                emit(b, 1'b1); to_flag();
            end
            lzss_pkg::PH_FLAG:
            begin
                flags = b; flags_left = 8; phase = lzss_pkg::PH_ITEM;
            end
            lzss_pkg::PH_ITEM:
            begin
                bit7 = flags[7];
                flags = flags << 1;
                if (flags_left > 0) flags_left--;
                if (!bit7)
                begin
                    emit(b, 1'b0); next_item();
                end
                else
                begin
                    ref_dist = b; phase = lzss_pkg::PH_REF1;
                end
            end
            lzss_pkg::PH_REF1:
            begin
                ref_dist |= 32'(b[3:0]) << 8;
                if (b[7:4] == 0) phase = lzss_pkg::PH_REF2;
                else begin_copy(32'(b[7:4]));
            end
            lzss_pkg::PH_REF2: begin_copy(32'(b) + 32'h10);
            default: ;
        endcase
    endfunction

    // Work out the result of one accepted transaction; returns 0 for no result
    function automatic bit predict_pixel(lzss_pkg::cmd_t c, logic [7:0] b, logic last,
                                         output lzss_pkg::result_t r);
        r = '{status: lzss_pkg::ST_TAKEN, pixel_value: 8'h00, pixel_transparent: 1'b0,
              pixel_last: 1'b0};
        case (c)
            lzss_pkg::CMD_PUSH:
            begin
                if (transp_left > 0 || opq_held || ref_left > 0)
                begin
                    r.status = lzss_pkg::ST_REFUSED;
                    return 1;
                end
                feed_byte(b);
                if (last)
                begin
                    phase = lzss_pkg::PH_STOP; ref_left = 0;
                end
                return 1;
            end
            lzss_pkg::CMD_PULL:
            begin
                if (longint'(n_pixels) >= img_area())
                begin
                    r.status = lzss_pkg::ST_DONE;
                    return 1;
                end
                if (pending_pixel(r)) return 1;
                if (ref_left > 0)
                begin
                    copy_byte();
                    if (pending_pixel(r)) return 1;
                    r.status = lzss_pkg::ST_NOPIX;
                    return 1;
                end
                if (phase == lzss_pkg::PH_STOP)
                begin
                    r = give_pixel(8'h00, 1'b0);
                    return 1;
                end
                r.status = lzss_pkg::ST_NOPIX;
                return 1;
            end
            lzss_pkg::CMD_START:
            begin
                clear_decoder();
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus side
    // ---------------------------------------------------------------
    task automatic send_item(lzss_pkg::cmd_t c, logic [7:0] b, logic last);
        lzss_pkg::result_t r;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct_in) @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= c;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge clk); while (!in_ch.ready);
        n_sent++;
        if (predict_pixel(c, b, last, r)) pixel_q.push_back(r);
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_reg(logic [3:0] idx, logic [10:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        if (idx == lzss_pkg::RegWidth) cur_width = val;
        else if (idx == lzss_pkg::RegHeight) cur_height = val;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Wait until every expected result is in, plus the pipeline depth
    task automatic drain();
        while (pixel_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_size(logic [10:0] w, logic [10:0] h);
        drain();
        write_reg(lzss_pkg::RegWidth, w);
        write_reg(lzss_pkg::RegHeight, h);
    endtask

    // Fixed number of pulls
    task automatic pull_out(int n);
        repeat (n) send_item(lzss_pkg::CMD_PULL, 8'h00, 1'b0);
    endtask

    // Three header bytes: an opening run/count pair that the body then follows
    task automatic send_header(logic [7:0] h0, logic [7:0] h1, logic [7:0] h2);
        send_item(lzss_pkg::CMD_START, 8'h00, 1'b0);
        send_item(lzss_pkg::CMD_PUSH, h0, 1'b0);
        send_item(lzss_pkg::CMD_PUSH, h1, 1'b0);
        send_item(lzss_pkg::CMD_PUSH, h2, 1'b0);
    endtask

    // Push a byte, pulling while the block refuses because pixels are pending
    task automatic push_drain(logic [7:0] b, logic last);
        int guard;
        guard = 0;
        while ((transp_left > 0 || opq_held || ref_left > 0) && guard < 600)
        begin
            send_item(lzss_pkg::CMD_PULL, 8'h00, 1'b0);
            guard++;
        end
        send_item(lzss_pkg::CMD_PUSH, b, last);
    endtask

    // Directed: headers, literals, a long reference with a bad distance, last-byte
    // stop, padding, zero area and the unused command
    task automatic test_directed();
        send_item(lzss_pkg::CMD_PULL, 8'h00, 1'b0);   // nothing decoded: no pixel
        send_header(8'h00, 8'hFF, 8'h80);
        push_drain(8'h00, 1'b0);                     // flag byte, all literals
        push_drain(8'hFF, 1'b0);
        push_drain(8'h01, 1'b1);                     // last byte stops decoding
        pull_out(3);
        send_item(lzss_pkg::CMD_PUSH, 8'h55, 1'b0);   // ignored after done
        send_item(lzss_pkg::CMD_NONE, 8'hAA, 1'b1);   // no result
        set_size(11'd16, 11'd4);
        send_header(8'h02, 8'h03, 8'h01);
        push_drain(8'h5A, 1'b0);                     // mixed flags
        push_drain(8'h02, 1'b0);
        push_drain(8'h01, 1'b0);                     // ref distance low
        push_drain(8'h02, 1'b0);                     // long form: distance high nibble
        push_drain(8'h20, 1'b0);                     // long length, bad distance: too far
        push_drain(8'h00, 1'b0);                     // flag byte, all literals
        push_drain(8'h00, 1'b0);
        push_drain(8'h01, 1'b0);
        push_drain(8'h00, 1'b0);                     // literal
        push_drain(8'hF0, 1'b0);
        pull_out(70);
        set_size(11'd0, 11'd5);                      // zero area
        send_item(lzss_pkg::CMD_START, 8'h00, 1'b0);
        send_item(lzss_pkg::CMD_PULL, 8'h00, 1'b0);
    endtask

    // Largest area and sides above the limit
    task automatic test_extremes();
        set_size(11'd1024, 11'd1024);                // extreme area, a few items only
        send_header(8'h00, 8'h00, 8'h00);
        pull_out(4);
        set_size(11'd2047, 11'd2047);                // above the side limit
        send_item(lzss_pkg::CMD_START, 8'h00, 1'b0);
        pull_out(2);
    endtask

    // Random well-formed streams with random content, plus noise
    task automatic test_random(int n_items);
        int start;
        int k;
        start = n_sent;
        while (n_sent - start < n_items)
        begin
            case ($urandom_range(5))
                0: set_size(11'($urandom_range(1, 12)), 11'($urandom_range(1, 12)));
                1: set_size(11'($urandom_range(1, 2047)), 11'($urandom_range(1, 3)));
                default: ;
            endcase
            send_header(8'($urandom_range(0, 6)), 8'($urandom), 8'($urandom_range(0, 4)));
            for (k = 0; k < $urandom_range(4, 40) && n_sent - start < n_items; k++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_item(lzss_pkg::cmd_t'($urandom_range(3)), 8'($urandom),
                              1'($urandom));
                end
                else if (phase == lzss_pkg::PH_REF1 && $urandom_range(3) != 0)
                begin
                    push_drain({4'($urandom), 4'h0}, 1'b0);   // short distance
                end
                else
                begin
                    push_drain(8'($urandom), ($urandom_range(49) == 0));
                end
            end
            for (k = 0; k < 40 && longint'(n_pixels) < img_area(); k++)
            begin
                send_item(lzss_pkg::CMD_PULL, 8'h00, 1'b0);
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering transactions
    task automatic test_backpressure();
        set_size(11'd8, 11'd8);
        out_hold = 1'b1;
        send_header(8'h01, 8'h02, 8'h03);
        repeat (20) send_item(lzss_pkg::CMD_PULL, 8'h00, 1'b0);
    endtask

    // ---------------------------------------------------------------
    // Result side: ready generation and checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !out_hold && ($urandom_range(99) >= idle_pct_out);
    end

    // Long hold-off counted in its own process
    initial
    begin
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (out_hold)
            begin
                held++;
                if (held >= 300)
                begin
                    out_hold = 1'b0;
                    held = 0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        lzss_pkg::result_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pixel_q.size() == 0)
            begin
                report_mismatch("unexpected result status", out_ch.status, -1);
            end
            else
            begin
                w = pixel_q.pop_front();
                if (out_ch.status !== w.status)
                    report_mismatch("status", out_ch.status, w.status);
                if (out_ch.pixel_value !== w.pixel_value)
                    report_mismatch("pixel_value", out_ch.pixel_value, w.pixel_value);
                if (out_ch.pixel_transparent !== w.pixel_transparent)
                    report_mismatch("pixel_transparent", out_ch.pixel_transparent,
                                    w.pixel_transparent);
                if (out_ch.pixel_last !== w.pixel_last)
                    report_mismatch("pixel_last", out_ch.pixel_last, w.pixel_last);
            end
        end
    end

    // Watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.cmd     = lzss_pkg::CMD_NONE;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        cfg.valid     = 1'b0;
        cfg.index     = lzss_pkg::RegWidth;
        cfg.data      = 11'd1;
        out_ch.ready  = 1'b0;
        cur_width     = 11'd1;
        cur_height    = 11'd1;
        clear_decoder();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_extremes();
        test_backpressure();
        // stretch with no idling, then the default rates
        idle_pct_in = 0; idle_pct_out = 0;
        test_random(200);
        idle_pct_in = 16; idle_pct_out = 16;
        test_random(650);

        drain();
        repeat (20) @(negedge clk);
        if (n_errors == 0 && pixel_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lzss_pkg.sv
rtl/core/lzss_if.sv
rtl/core/lzss_ctrl.sv
rtl/core/lzss_dp.sv
rtl/core/lzss_pixel_decompressor.sv
tb/sv/tb_lzss_pixel_decompressor.sv
